// File: sv/lru_page_replacement_top_macros.svh
// Assertion macros for the LRU page replacement block.
// Used by lru_page_replacement_top; expects signals clk and rst_n in scope.
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpr assertion failed");
`define LPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpr assertion failed");
`else
`define LPR_ASSERT_IMP(lbl, ante, cons)
`define LPR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/lpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LRU page replacement block.
// No dependencies.
package lpr_pkg;

  localparam int PAGE_W     = 16;
  localparam int TS_W       = 32;
  localparam int FAULT_W    = 16;
  localparam int CFG_W      = 5;
  localparam int FIDX_W     = 4;
  localparam int SCAN_IDX_W = 6;  // covers the largest frame count, 64

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_COMMIT
  } lpr_state_t;

  // Broadcast write to the cells
  typedef struct packed {
    logic              clr;
    logic [PAGE_W-1:0] page;
    logic [TS_W-1:0]   ts;
  } lpr_wr_t;

  // Victim search token passed cell to cell
  typedef struct packed {
    logic                  act;
    logic [TS_W-1:0]       min_ts;
    logic [SCAN_IDX_W-1:0] idx;
  } lpr_scan_t;

endpackage

// File: sv/lpr_cell.sv
`timescale 1ns / 1ps
// One page frame: resident page, valid bit, last-use stamp and one stage
// of the oldest-frame search chain. Depends on lpr_pkg.
module lpr_cell import lpr_pkg::*; #(
  parameter int CELL_ID = 0,
  parameter int NW      = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NW-1:0]     frames_n,
  input  logic [PAGE_W-1:0] probe_page,
  output logic              hit,
  input  logic              wr_en,
  input  lpr_wr_t           wr,
  input  lpr_scan_t         scan_in,
  output lpr_scan_t         scan_out
);

  logic              valid_r;
  logic [PAGE_W-1:0] page_r;
  logic [TS_W-1:0]   ts_r;
  lpr_scan_t         scan_r, scan_nxt;
  logic              in_range;
  logic              take;

  assign in_range = frames_n > NW'(CELL_ID);
  assign hit      = valid_r && in_range && (page_r == probe_page);

  // first frame seeds the search; later ones replace only if strictly older
  assign take = scan_in.act && ((CELL_ID == 0) || (in_range && (ts_r < scan_in.min_ts)));

  always_comb begin
    scan_nxt = scan_in;
    if (take) begin
      scan_nxt.min_ts = ts_r;
      scan_nxt.idx    = SCAN_IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (wr.clr) begin
        valid_r <= 1'b0;
      end else if (wr_en) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r <= wr.page;
      ts_r   <= wr.ts;
    end
  end

  assign scan_out = scan_r;

endmodule

// File: sv/lru_page_replacement_top.sv
`timescale 1ns / 1ps
// LRU page replacement: a hit or a fill is resolved in the LOOK state after
// acceptance and its result registered, unless the output stalls. An eviction
// first runs the search token down the row of FRAMES cells. No new item is
// accepted until the result of the last one has been committed.
// Synchronous active-low reset clears all frames, counters and sets
// num_frames to 16; no clearing pass is needed.
`include "lru_page_replacement_top_macros.svh"
module lru_page_replacement_top import lpr_pkg::*; #(
  parameter int FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata,   // num_frames
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // page
  input  logic        in_tlast,    // last_ref
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // hit, frame_index[3:0], fault_count[15:0]
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]   num_frames_r;
  lpr_state_t         state_r, state_nxt;
  logic [PAGE_W-1:0]  page_r;
  logic               last_r;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               hit_r, hit_nxt;
  logic               fill_use_r, fill_use_nxt;
  logic [NW-1:0]      fill_r;
  logic [TS_W-1:0]    ref_clock_r, ref_clock_new;
  logic [FAULT_W-1:0] faults_r, faults_new;
  logic               out_tvalid_r;
  logic [23:0]        out_tdata_r;

  logic [7:0]         cfg_ext, n8;
  logic [NW-1:0]      frames_n;
  logic [FRAMES-1:0]  hv;
  logic               found;
  logic [IW-1:0]      hit_idx;
  logic               fill_free;
  logic               out_free;
  logic               cm_go, cm_hit, cm_fill;
  logic [IW-1:0]      cm_slot;
  logic               scan_start, scan_done;
  logic [IW+3:0]      slot_ext;
  lpr_wr_t            wr;
  lpr_scan_t          chain [FRAMES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= CFG_W'(16);
    end else if (cfg_wen) begin
      num_frames_r <= cfg_wdata;
    end
  end

  always_comb begin
    cfg_ext = {3'b000, num_frames_r};
    if (cfg_ext == 8'd0) begin
      n8 = 8'd1;
    end else if (cfg_ext > 8'(FRAMES)) begin
      n8 = 8'(FRAMES);
    end else begin
      n8 = cfg_ext;
    end
  end
  assign frames_n = n8[NW-1:0];

  // frame row
  assign wr.clr  = cm_go && last_r;
  assign wr.page = page_r;
  assign wr.ts   = ref_clock_r;

  assign chain[0].act    = scan_start;
  assign chain[0].min_ts = '0;
  assign chain[0].idx    = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lpr_cell #(
      .CELL_ID (i),
      .NW      (NW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .frames_n   (frames_n),
      .probe_page (page_r),
      .hit        (hv[i]),
      .wr_en      (cm_go && (cm_slot == IW'(i))),
      .wr         (wr),
      .scan_in    (chain[i]),
      .scan_out   (chain[i+1])
    );
  end

  assign scan_done = chain[FRAMES].act;

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hv[i]) begin
        found   = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign fill_free = fill_r < frames_n;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    hit_nxt      = hit_r;
    fill_use_nxt = fill_use_r;
    cm_go        = 1'b0;
    cm_slot      = slot_r;
    cm_hit       = hit_r;
    cm_fill      = fill_use_r;
    scan_start   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (found || fill_free) begin
          slot_nxt     = found ? hit_idx : fill_r[IW-1:0];
          hit_nxt      = found;
          fill_use_nxt = !found;
          cm_slot      = slot_nxt;
          cm_hit       = hit_nxt;
          cm_fill      = fill_use_nxt;
          if (out_free) begin
            cm_go     = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end else begin
          scan_start   = 1'b1;
          hit_nxt      = 1'b0;
          fill_use_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          slot_nxt  = chain[FRAMES].idx[IW-1:0];
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cm_go     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      page_r <= in_tdata;
      last_r <= in_tlast;
    end
    slot_r     <= slot_nxt;
    hit_r      <= hit_nxt;
    fill_use_r <= fill_use_nxt;
  end

  always_comb begin
    faults_new = faults_r;
    if (!cm_hit && (faults_r != {FAULT_W{1'b1}})) begin
      faults_new = faults_r + FAULT_W'(1);
    end
    ref_clock_new = ref_clock_r;
    if (ref_clock_r != {TS_W{1'b1}}) begin
      ref_clock_new = ref_clock_r + TS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      faults_r    <= '0;
      ref_clock_r <= '0;
    end else if (cm_go) begin
      if (last_r) begin
        fill_r      <= '0;
        faults_r    <= '0;
        ref_clock_r <= '0;
      end else begin
        if (cm_fill) begin
          fill_r <= fill_r + NW'(1);
        end
        faults_r    <= faults_new;
        ref_clock_r <= ref_clock_new;
      end
    end
  end

  // output stage
  assign slot_ext = {4'b0000, cm_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cm_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cm_go) begin
      out_tdata_r <= {3'b000, faults_new, slot_ext[3:0], cm_hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `LPR_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= NW'(FRAMES))
  `LPR_ASSERT_IMP(a_scan_in_state, scan_done, state_r == ST_SCAN)
  `LPR_ASSERT_NXT(a_clock_runs, cm_go && !last_r, ref_clock_r != '0)
  `LPR_ASSERT_NXT(a_commit_shows, cm_go, out_tvalid && state_r == ST_IDLE)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement_top: page references in, hit/frame/fault
// results out, all compared with an LRU predictor kept inside this file. Needs lpr_pkg.
module testbench;
  import lpr_pkg::*;

  localparam int FRAMES         = 16;
  localparam int IDLE_MAX       = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MISS_REFS      = 40;
  localparam int CHUNKS         = 13;
  localparam int CHUNK_REFS     = 100;
  localparam int N_DIRECTED     = 22;
  localparam logic [PAGE_W-1:0] DIRECTED [N_DIRECTED] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
    16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
    16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C,
    16'h1234, 16'h0000, 16'hAAAA, 16'h0000
  };
  localparam int DIRECTED_LAST = 20;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
  } page_ref_t;

  typedef struct packed {
    logic               hit;
    logic [FIDX_W-1:0]  frame;
    logic [FAULT_W-1:0] faults;
  } lru_outcome_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic [4:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // page
  logic        in_tlast   = 1'b0; // last_ref
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // hit, frame_index[3:0], fault_count[15:0]

  page_ref_t    page_refs[$];
  lru_outcome_t lru_outcomes[$];

  // predictor state
  logic [PAGE_W-1:0]  res_page  [FRAMES];
  logic               res_valid [FRAMES];
  logic [TS_W-1:0]    res_stamp [FRAMES];
  int                 fill_next;
  logic [TS_W-1:0]    stamp_now;
  logic [FAULT_W-1:0] fault_total;
  logic [CFG_W-1:0]   frames_cfg = 5'd16;

  int tx_idle_max = IDLE_MAX;
  int rx_idle_max = IDLE_MAX;
  int tx_gap      = 0;
  int rx_stall    = 0;
  int errors      = 0;
  int quiet_cycles = 0;

  lru_page_replacement_top #(.FRAMES(FRAMES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_string();
    for (int i = 0; i < FRAMES; i++) begin
      res_page[i]  = '0;
      res_valid[i] = 1'b0;
      res_stamp[i] = '0;
    end
    fill_next   = 0;
    stamp_now   = '0;
    fault_total = '0;
  endfunction

  function automatic lru_outcome_t lru_access(logic [PAGE_W-1:0] pg, logic last);
    lru_outcome_t    o;
    int              n;
    int              slot;
    bit              found;
    logic [TS_W-1:0] oldest;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && res_valid[i] && res_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (fill_next < n) begin
        slot = fill_next;
        fill_next++;
      end else begin
        oldest = res_stamp[0];
        for (int i = 1; i < n; i++) begin
          if (res_stamp[i] < oldest) begin
            oldest = res_stamp[i];
            slot   = i;
          end
        end
      end
      res_page[slot]  = pg;
      res_valid[slot] = 1'b1;
      if (fault_total != '1) fault_total++;
    end
    res_stamp[slot] = stamp_now;
    if (stamp_now != '1) stamp_now++;
    o.hit    = found;
    o.frame  = slot[FIDX_W-1:0];
    o.faults = fault_total;
    if (last) clear_string();
    return o;
  endfunction

  // driver: takes items from page_refs, predicts each one as it is accepted
  always @(posedge clk) begin : ref_driver
    page_ref_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) lru_outcomes.push_back(lru_access(in_tdata, in_tlast));
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (page_refs.size() != 0) begin
          nxt = page_refs.pop_front();
          in_tdata  <= nxt.page;
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
          tx_gap    <= $urandom_range(0, tx_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin : result_monitor
    lru_outcome_t exp_o;
    int           s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else begin
      s = rx_stall;
      if (out_tvalid && out_tready) begin
        if (lru_outcomes.size() == 0) begin
          $error("result 0x%06h with no reference outstanding", out_tdata);
          errors++;
        end else begin
          exp_o = lru_outcomes.pop_front();
          if (out_tdata[0] !== exp_o.hit) begin
            $error("hit: expected %0d, actual %0d", exp_o.hit, out_tdata[0]);
            errors++;
          end
          if (out_tdata[4:1] !== exp_o.frame) begin
            $error("frame_index: expected %0d, actual %0d", exp_o.frame, out_tdata[4:1]);
            errors++;
          end
          if (out_tdata[20:5] !== exp_o.faults) begin
            $error("fault_count: expected %0d, actual %0d", exp_o.faults, out_tdata[20:5]);
            errors++;
          end
        end
        s = $urandom_range(0, rx_idle_max);
      end else if (s > 0) begin
        s--;
      end
      rx_stall   <= s;
      out_tready <= (s == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (page_refs.size() != 0 || in_tvalid || lru_outcomes.size() != 0);
    repeat (FRAMES + 4) @(negedge clk);
  endtask

  task automatic set_frames(logic [4:0] v);
    drain();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    frames_cfg = v;
  endtask

  task automatic pick_idling();
    tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
    rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
  endtask

  initial begin : stimulus
    logic [4:0]        v;
    logic [PAGE_W-1:0] base;
    int                pool;
    clear_string();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      page_refs.push_back('{page: DIRECTED[i], last: (i == DIRECTED_LAST)});

    // random strings; register values change between chunks without clearing
    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0:       v = 5'd0;
        1:       v = 5'd1;
        2:       v = 5'd4;
        3:       v = 5'd31;
        4:       v = 5'd2;
        5:       v = 5'd17;
        6:       v = 5'd16;
        default: v = 5'($urandom_range(0, 31));
      endcase
      set_frames(v);
      pick_idling();
      case ($urandom_range(0, 3))
        0:       pool = 3;
        1:       pool = 12;
        2:       pool = 40;
        default: pool = 65535;
      endcase
      base = 16'($urandom_range(0, 65535));
      @(negedge clk);
      for (int i = 0; i < CHUNK_REFS; i++)
        page_refs.push_back('{page: 16'(base + $urandom_range(0, pool)),
                              last: ($urandom_range(0, 39) == 0)});
    end

    // back-to-back miss run on a single frame, then clear
    set_frames(5'd1);
    tx_idle_max = 0;
    rx_idle_max = 0;
    @(negedge clk);
    for (int i = 0; i < MISS_REFS; i++)
      page_refs.push_back('{page: 16'(i), last: (i == MISS_REFS - 1)});
    page_refs.push_back('{page: 16'h0000, last: 1'b0});
    page_refs.push_back('{page: 16'h0000, last: 1'b1});

    drain();
    if (errors == 0 && lru_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
